### rtl/core/dlta_pkg.sv
// shared types, widths and register indexes for the dynamic light texel accumulator
// no dependencies
package dlta_pkg;

  localparam int unsigned TEXEL_W    = 6;
  localparam int unsigned BASE_W     = 8;
  localparam int unsigned POS_W      = 19;
  localparam int unsigned PD_W       = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned STR_W      = 20;
  localparam int unsigned COLOR_W    = 30;
  localparam int unsigned CH_W       = 10;
  localparam int unsigned MAG_W      = 19;
  localparam int unsigned OFF_W      = 23;
  localparam int unsigned D_W        = 46;
  localparam int unsigned HS_W       = 36;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned I8_W       = 18;
  localparam int unsigned ADD_W      = 12;
  localparam int unsigned MAX_SIDE   = 64;
  localparam int unsigned I8_MAX     = 131072;
  localparam int unsigned LIT_MIN    = 256;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_U        = 3'd0,
    REG_LIGHT_V        = 3'd1,
    REG_PLANE_DISTANCE = 3'd2,
    REG_SCALE_U        = 3'd3,
    REG_SCALE_V        = 3'd4,
    REG_LIGHT_STRENGTH = 3'd5,
    REG_LIGHT_COLOR    = 3'd6,
    REG_COLORED_MODE   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [BASE_W-1:0] red;
    logic [BASE_W-1:0] green;
    logic [BASE_W-1:0] blue;
  } base_t;

  typedef struct packed {
    base_t            base;
    logic             active;
    logic [D_W-1:0]   d;
    logic [HS_W-1:0]  hs;
  } sqrt_side_t;

  typedef struct packed {
    base_t              base;
    logic               active;
    logic [ROOT_W-1:0]  root;
  } div1_side_t;

  typedef struct packed {
    base_t base;
    logic  active;
    logic  ovf;
  } div2_side_t;

endpackage

### rtl/core/dlta_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, sideband carried along
// depends on nothing but its parameters
module dlta_sqrt_pipe #(
  parameter int unsigned R_BITS = 31,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*R_BITS-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [R_BITS-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  logic                  st_valid [R_BITS];
  logic [R_BITS+1:0]     st_rem   [R_BITS];
  logic [R_BITS-1:0]     st_root  [R_BITS];
  logic [2*R_BITS-1:0]   st_rad   [R_BITS];
  logic [SIDE_W-1:0]     st_side  [R_BITS];

  logic                  p_valid  [R_BITS];
  logic [R_BITS+1:0]     p_rem    [R_BITS];
  logic [R_BITS-1:0]     p_root   [R_BITS];
  logic [2*R_BITS-1:0]   p_rad    [R_BITS];
  logic [SIDE_W-1:0]     p_side   [R_BITS];

  logic [R_BITS+1:0]     n_rem    [R_BITS];
  logic [R_BITS-1:0]     n_root   [R_BITS];

  always_comb begin
    logic [R_BITS+3:0] shifted;
    logic [R_BITS+3:0] trial;
    logic              ge;
    p_valid[0] = in_valid;
    p_rem[0]   = '0;
    p_root[0]  = '0;
    p_rad[0]   = in_rad;
    p_side[0]  = in_side;
    for (int i = 1; i < R_BITS; i++) begin
      p_valid[i] = st_valid[i-1];
      p_rem[i]   = st_rem[i-1];
      p_root[i]  = st_root[i-1];
      p_rad[i]   = {st_rad[i-1][2*R_BITS-3:0], 2'b00};
      p_side[i]  = st_side[i-1];
    end
    for (int i = 0; i < R_BITS; i++) begin
      shifted   = {p_rem[i], p_rad[i][2*R_BITS-1:2*R_BITS-2]};
      trial     = {2'b00, p_root[i], 2'b01};
      ge        = shifted >= trial;
      n_rem[i]  = ge ? (R_BITS+2)'(shifted - trial) : shifted[R_BITS+1:0];
      n_root[i] = {p_root[i][R_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < R_BITS; i++) st_valid[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < R_BITS; i++) st_valid[i] <= p_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < R_BITS; i++) begin
        st_rem[i]  <= n_rem[i];
        st_root[i] <= n_root[i];
        st_rad[i]  <= p_rad[i];
        st_side[i] <= p_side[i];
      end
    end
  end

  assign out_valid = st_valid[R_BITS-1];
  assign out_root  = st_root[R_BITS-1];
  assign out_side  = st_side[R_BITS-1];

endmodule

### rtl/core/dlta_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, sideband carried along
// depends on nothing but its parameters; needs in_rem below in_den
module dlta_div_pipe #(
  parameter int unsigned DEN_W  = 46,
  parameter int unsigned Q_BITS = 64,
  parameter int unsigned SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DEN_W-1:0]   in_rem,
  input  logic [Q_BITS-1:0]  in_acc,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [Q_BITS-1:0]  out_quot,
  output logic [SIDE_W-1:0]  out_side
);

  logic               st_valid [Q_BITS];
  logic [DEN_W-1:0]   st_rem   [Q_BITS];
  logic [Q_BITS-1:0]  st_acc   [Q_BITS];
  logic [DEN_W-1:0]   st_den   [Q_BITS];
  logic [SIDE_W-1:0]  st_side  [Q_BITS];

  logic               p_valid  [Q_BITS];
  logic [DEN_W-1:0]   p_rem    [Q_BITS];
  logic [Q_BITS-1:0]  p_acc    [Q_BITS];
  logic [DEN_W-1:0]   p_den    [Q_BITS];
  logic [SIDE_W-1:0]  p_side   [Q_BITS];

  logic [DEN_W-1:0]   n_rem    [Q_BITS];
  logic [Q_BITS-1:0]  n_acc    [Q_BITS];

  always_comb begin
    logic [DEN_W:0] trial;
    logic           ge;
    p_valid[0] = in_valid;
    p_rem[0]   = in_rem;
    p_acc[0]   = in_acc;
    p_den[0]   = in_den;
    p_side[0]  = in_side;
    for (int i = 1; i < Q_BITS; i++) begin
      p_valid[i] = st_valid[i-1];
      p_rem[i]   = st_rem[i-1];
      p_acc[i]   = st_acc[i-1];
      p_den[i]   = st_den[i-1];
      p_side[i]  = st_side[i-1];
    end
    for (int i = 0; i < Q_BITS; i++) begin
      trial    = {p_rem[i], p_acc[i][Q_BITS-1]};
      ge       = trial >= {1'b0, p_den[i]};
      n_rem[i] = ge ? DEN_W'(trial - {1'b0, p_den[i]}) : trial[DEN_W-1:0];
      n_acc[i] = {p_acc[i][Q_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_BITS; i++) st_valid[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < Q_BITS; i++) st_valid[i] <= p_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_BITS; i++) begin
        st_rem[i]  <= n_rem[i];
        st_acc[i]  <= n_acc[i];
        st_den[i]  <= p_den[i];
        st_side[i] <= p_side[i];
      end
    end
  end

  assign out_valid = st_valid[Q_BITS-1];
  assign out_quot  = st_acc[Q_BITS-1];
  assign out_side  = st_side[Q_BITS-1];

endmodule

### rtl/core/dynamic_light_texel_accumulate_top.sv
// pipeline: 4 offset/square stages, 31 root stages, 64 + 18 divide stages, 4 more
// throughput one texel per cycle; the whole pipe holds while a result waits untaken
// one quotient or root bit per stage sets the depth
// rst (synchronous) clears valid bits and loads register defaults; no memory to clear
// depends on dlta_pkg, dlta_sqrt_pipe, dlta_div_pipe
module dynamic_light_texel_accumulate_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // texel_x, texel_y, base_red, base_green, base_blue, zero pad
  input  logic [dlta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // lit_red, lit_green, lit_blue
  output logic [dlta_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // was_lit
  output logic [dlta_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [dlta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlta_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dlta_pkg::*;

  logic signed [POS_W-1:0] light_u;
  logic signed [POS_W-1:0] light_v;
  logic signed [PD_W-1:0]  plane_distance;
  logic [SCALE_W-1:0]      scale_u;
  logic [SCALE_W-1:0]      scale_v;
  logic [STR_W-1:0]        light_strength;
  logic [COLOR_W-1:0]      light_color;
  logic                    colored_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_u        <= '0;
      light_v        <= '0;
      plane_distance <= '0;
      scale_u        <= SCALE_W'(4096);
      scale_v        <= SCALE_W'(4096);
      light_strength <= '0;
      light_color    <= '0;
      colored_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIGHT_U:        light_u        <= cfg_data[POS_W-1:0];
        REG_LIGHT_V:        light_v        <= cfg_data[POS_W-1:0];
        REG_PLANE_DISTANCE: plane_distance <= cfg_data[PD_W-1:0];
        REG_SCALE_U:        scale_u        <= cfg_data[SCALE_W-1:0];
        REG_SCALE_V:        scale_v        <= cfg_data[SCALE_W-1:0];
        REG_LIGHT_STRENGTH: light_strength <= cfg_data[STR_W-1:0];
        REG_LIGHT_COLOR:    light_color    <= cfg_data[COLOR_W-1:0];
        REG_COLORED_MODE:   colored_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: offsets from the light
  logic [TEXEL_W-1:0] in_x, in_y;
  base_t              in_base;
  logic [POS_W:0]     diff_u, diff_v;
  assign in_x          = s_axis_tdata[5:0];
  assign in_y          = s_axis_tdata[11:6];
  assign in_base.red   = s_axis_tdata[19:12];
  assign in_base.green = s_axis_tdata[27:20];
  assign in_base.blue  = s_axis_tdata[35:28];
  assign diff_u = {6'b0, in_x, 8'b0} - {light_u[POS_W-1], light_u};
  assign diff_v = {6'b0, in_y, 8'b0} - {light_v[POS_W-1], light_v};

  logic             v1, active1;
  base_t            base1;
  logic [MAG_W-1:0] mag_u1, mag_v1;

  // stage 2: scaled offsets
  logic             v2, active2;
  base_t            base2;
  logic [OFF_W-1:0] du2, dv2;
  logic [MAG_W+SCALE_W-1:0] prod_u, prod_v;
  assign prod_u = mag_u1 * scale_u;
  assign prod_v = mag_v1 * scale_v;

  // stage 3: squares and height times strength
  logic            v3, active3;
  base_t           base3;
  logic [D_W-1:0]  du_sq3, dv_sq3;
  logic [31:0]     h_sq3;
  logic [HS_W-1:0] hs3;
  logic [PD_W-1:0] h8;
  assign h8 = PD_W'(plane_distance) + PD_W'(16);

  // stage 4: distance squared
  logic            v4;
  sqrt_side_t      sq_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base1   <= in_base;
      active1 <= !plane_distance[PD_W-1] && (9'(in_x) < 9'(MAX_SIDE))
                 && (9'(in_y) < 9'(MAX_SIDE));
      mag_u1  <= diff_u[POS_W] ? MAG_W'(-diff_u) : diff_u[MAG_W-1:0];
      mag_v1  <= diff_v[POS_W] ? MAG_W'(-diff_v) : diff_v[MAG_W-1:0];

      base2   <= base1;
      active2 <= active1;
      du2     <= prod_u[MAG_W+SCALE_W-1:12];
      dv2     <= prod_v[MAG_W+SCALE_W-1:12];

      base3   <= base2;
      active3 <= active2;
      du_sq3  <= du2 * du2;
      dv_sq3  <= dv2 * dv2;
      h_sq3   <= h8 * h8;
      hs3     <= h8 * light_strength;

      sq_in.base   <= base3;
      sq_in.active <= active3;
      sq_in.d      <= D_W'(du_sq3 + dv_sq3 + D_W'(h_sq3));
      sq_in.hs     <= hs3;
    end
  end

  // square root of d scaled by 2^16
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_out;

  dlta_sqrt_pipe #(
    .R_BITS (ROOT_W),
    .SIDE_W ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rad    ({sq_in.d, 16'b0}),
    .in_side   (sq_in),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_out)
  );

  // numerator over d
  div1_side_t       d1_in, d1_out;
  logic             d1_v;
  logic [NUM_W-1:0] quot1;
  assign d1_in.base   = sq_out.base;
  assign d1_in.active = sq_out.active;
  assign d1_in.root   = sq_root;

  dlta_div_pipe #(
    .DEN_W  (D_W),
    .Q_BITS (NUM_W),
    .SIDE_W ($bits(div1_side_t))
  ) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .in_rem    ('0),
    .in_acc    ({sq_out.hs, 28'b0}),
    .in_den    (sq_out.d),
    .in_side   (d1_in),
    .out_valid (d1_v),
    .out_quot  (quot1),
    .out_side  (d1_out)
  );

  // stage 5: overflow check, then only the low quotient bits go through the divider
  logic              v5;
  div2_side_t        d2_in, d2_out;
  logic [ROOT_W-1:0] rem5, root5;
  logic [I8_W-1:0]   acc5;
  logic              ovf;
  assign ovf = quot1[NUM_W-1:I8_W] >= (NUM_W-I8_W)'(d1_out.root);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_in.base   <= d1_out.base;
      d2_in.active <= d1_out.active;
      d2_in.ovf    <= ovf;
      rem5         <= ovf ? '0 : quot1[I8_W+ROOT_W-1:I8_W];
      acc5         <= quot1[I8_W-1:0];
      root5        <= d1_out.root;
    end
  end

  logic            d2_v;
  logic [I8_W-1:0] quot2;

  dlta_div_pipe #(
    .DEN_W  (ROOT_W),
    .Q_BITS (I8_W),
    .SIDE_W ($bits(div2_side_t))
  ) u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_rem    (rem5),
    .in_acc    (acc5),
    .in_den    (root5),
    .in_side   (d2_in),
    .out_valid (d2_v),
    .out_quot  (quot2),
    .out_side  (d2_out)
  );

  // stage 6: clamp and lit decision
  logic            v6, lit6;
  base_t           base6;
  logic [I8_W-1:0] i8_6, i8_clamped;
  assign i8_clamped = (d2_out.ovf || quot2 > I8_W'(I8_MAX)) ? I8_W'(I8_MAX) : quot2;

  // stage 7: light contribution per channel
  logic             v7, lit7;
  base_t            base7;
  logic [ADD_W-1:0] add_r7, add_g7, add_b7;
  logic [CH_W+I8_W-1:0] pr_r, pr_g, pr_b;
  assign pr_r = light_color[9:0] * i8_6;
  assign pr_g = light_color[19:10] * i8_6;
  assign pr_b = light_color[29:20] * i8_6;

  // stage 8: saturating add into the output register; grey mode zeroes green and blue
  logic [ADD_W:0] sum_r, sum_g, sum_b;
  logic [BASE_W-1:0] sat_r, sat_g, sat_b;
  assign sum_r = (ADD_W+1)'(base7.red) + (ADD_W+1)'(add_r7);
  assign sum_g = (ADD_W+1)'(base7.green) + (ADD_W+1)'(add_g7);
  assign sum_b = (ADD_W+1)'(base7.blue) + (ADD_W+1)'(add_b7);
  assign sat_r = (sum_r > (ADD_W+1)'(255)) ? 8'hFF : sum_r[BASE_W-1:0];
  assign sat_g = (sum_g > (ADD_W+1)'(255)) ? 8'hFF : sum_g[BASE_W-1:0];
  assign sat_b = (sum_b > (ADD_W+1)'(255)) ? 8'hFF : sum_b[BASE_W-1:0];

  logic [BASE_W-1:0] out_r, out_g, out_b;
  logic              out_lit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6            <= 1'b0;
      v7            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v6            <= d2_v;
      v7            <= v6;
      m_axis_tvalid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base6 <= d2_out.base;
      i8_6  <= i8_clamped;
      lit6  <= d2_out.active && (i8_clamped > I8_W'(LIT_MIN));

      base7  <= base6;
      lit7   <= lit6;
      add_r7 <= colored_mode ? pr_r[CH_W+I8_W-1:16] : ADD_W'(i8_6[I8_W-1:8]);
      add_g7 <= pr_g[CH_W+I8_W-1:16];
      add_b7 <= pr_b[CH_W+I8_W-1:16];

      out_r   <= lit7 ? sat_r : base7.red;
      out_g   <= colored_mode ? (lit7 ? sat_g : base7.green) : '0;
      out_b   <= colored_mode ? (lit7 ? sat_b : base7.blue) : '0;
      out_lit <= lit7;
    end
  end

  assign m_axis_tdata = {out_b, out_g, out_r};
  assign m_axis_tuser = out_lit;

  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !colored_mode |-> m_axis_tdata[23:8] == '0)
    else $error("grey mode result carries green or blue");

  a_lit_front: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !plane_distance[PD_W-1])
    else $error("texel lit by a light behind the plane");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    v6 |-> i8_6 <= I8_W'(I8_MAX))
    else $error("intensity above clamp");

  a_lit_needs_i8: assert property (@(posedge clk) disable iff (rst)
    v6 && lit6 |-> i8_6 > I8_W'(LIT_MIN))
    else $error("lit flag without intensity");

endmodule
